[hdl/hzc_pkg.sv]
// Shared types and constants of the hexagon canopy cover unit.
`timescale 1ns / 1ps
`default_nettype none
package hzc_pkg;

	localparam int INDEX_BITS_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 8;

	localparam int FIELD_W    = 16;
	localparam int COORD_W    = 40;
	localparam int STEP_W     = 24;
	localparam int EDGE_W     = 39;
	localparam int THR_W      = 17;
	localparam int CNT_W      = 32;
	localparam int FRAC_W     = 17;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 40;

	localparam int PIPE_STAGES = 7;
	localparam int THR_SHIFT   = 15;
	localparam int PX_W        = COORD_W + 3;
	localparam int ABS_W       = PX_W - 1;
	localparam int EDGE2_W     = EDGE_W + 1;
	localparam int SQ_IN_W     = EDGE2_W + 1;
	localparam int SQ_LO_W     = 21;
	localparam int SQ_HI_W     = SQ_IN_W - SQ_LO_W;
	localparam int SQ_W        = 2 * SQ_IN_W;
	localparam int CMP_W       = SQ_W + 2;

	localparam logic signed [STEP_W-1:0] STEP_X_RST = 24'sd256;
	localparam logic signed [STEP_W-1:0] STEP_Y_RST = -24'sd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X     = 4'd0,
		REG_ORIGIN_Y     = 4'd1,
		REG_STEP_X       = 4'd2,
		REG_STEP_Y       = 4'd3,
		REG_HEX_CENTER_X = 4'd4,
		REG_HEX_CENTER_Y = 4'd5,
		REG_HEX_EDGE     = 4'd6,
		REG_NDVI_THR     = 4'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_COUNT,
		ST_LOAD,
		ST_DIV,
		ST_SEND
	} back_state_t;

	typedef struct packed {
		logic sampled;
		logic canopy;
		logic last_pixel;
	} class_t;

endpackage
`default_nettype wire

[hdl/hzc_front.sv]
// Front end: configuration registers, pixel placement, hexagon and NDVI tests.
`timescale 1ns / 1ps
`default_nettype none
module hzc_front import hzc_pkg::*; #(
	parameter int INDEX_BITS  = INDEX_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [FIELD_W-1:0]    column,
	input  wire logic [FIELD_W-1:0]    row,
	input  wire logic [FIELD_W-1:0]    red_value,
	input  wire logic [FIELD_W-1:0]    nir_value,
	input  wire logic                  last_pixel,
	output logic                       cls_valid,
	output class_t                     cls,
	input  wire logic                  cls_release
);

	localparam int ODD_W  = INDEX_BITS + 1;
	localparam int PROD_W = ODD_W + STEP_W;
	localparam int SUM_W  = SAMPLE_BITS + 1;
	localparam int NDV_W  = SAMPLE_BITS + 19;
	localparam int CRD_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int HH_W   = 2 * SQ_HI_W;
	localparam int LL_W   = 2 * SQ_LO_W;
	localparam int SQ_LANES = 4;
	localparam int LANE_DX  = 0;
	localparam int LANE_E   = 1;
	localparam int LANE_DY  = 2;
	localparam int LANE_R   = 3;

	logic signed [COORD_W-1:0] origin_x_q, origin_y_q, center_x_q, center_y_q;
	logic signed [STEP_W-1:0]  step_x_q, step_y_q;
	logic [EDGE_W-1:0]         edge_q;
	logic signed [THR_W-1:0]   ndvi_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			step_x_q   <= STEP_X_RST;
			step_y_q   <= STEP_Y_RST;
			center_x_q <= '0;
			center_y_q <= '0;
			edge_q     <= '0;
			ndvi_thr_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ORIGIN_X:     origin_x_q <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Y:     origin_y_q <= cfg_data[COORD_W-1:0];
				REG_STEP_X:       step_x_q   <= cfg_data[STEP_W-1:0];
				REG_STEP_Y:       step_y_q   <= cfg_data[STEP_W-1:0];
				REG_HEX_CENTER_X: center_x_q <= cfg_data[COORD_W-1:0];
				REG_HEX_CENTER_Y: center_y_q <= cfg_data[COORD_W-1:0];
				REG_HEX_EDGE:     edge_q     <= cfg_data[EDGE_W-1:0];
				REG_NDVI_THR:     ndvi_thr_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// credit count covers items in flight and items waiting in the queue
	logic             accept;
	logic [CRD_W-1:0] used_q;

	assign full   = (used_q == CRD_W'(QUEUE_DEPTH));
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (accept && !cls_release) begin
			used_q <= used_q + 1'b1;
		end else if (!accept && cls_release) begin
			used_q <= used_q - 1'b1;
		end
	end

	logic [PIPE_STAGES-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_STAGES-2:0], accept};
		end
	end

	// stage 1: column/row products and NDVI right-hand side
	logic [ODD_W-1:0]         odd_col, odd_row;
	logic signed [ODD_W:0]    odd_col_s, odd_row_s;
	logic [SAMPLE_BITS-1:0]   red_s, nir_s;
	logic [SUM_W-1:0]         band_sum;
	logic signed [SUM_W-1:0]  band_diff;
	logic signed [NDV_W-1:0]  rhs_prod;

	assign odd_col   = {column[INDEX_BITS-1:0], 1'b1};
	assign odd_row   = {row[INDEX_BITS-1:0], 1'b1};
	assign odd_col_s = $signed({1'b0, odd_col});
	assign odd_row_s = $signed({1'b0, odd_row});
	assign red_s     = red_value[SAMPLE_BITS-1:0];
	assign nir_s     = nir_value[SAMPLE_BITS-1:0];
	assign band_sum  = {1'b0, red_s} + {1'b0, nir_s};
	assign band_diff = $signed({1'b0, nir_s}) - $signed({1'b0, red_s});
	assign rhs_prod  = NDV_W'(ndvi_thr_q) * NDV_W'($signed({1'b0, band_sum}));

	logic signed [PROD_W-1:0] pm_x_s1, pm_y_s1;
	logic signed [NDV_W-1:0]  rhs_s1;
	logic signed [SUM_W-1:0]  diff_s1;
	logic                     nz_s1, last_s1;

	always_ff @(posedge clk) begin
		pm_x_s1 <= PROD_W'(odd_col_s) * PROD_W'(step_x_q);
		pm_y_s1 <= PROD_W'(odd_row_s) * PROD_W'(step_y_q);
		rhs_s1  <= rhs_prod;
		diff_s1 <= band_diff;
		nz_s1   <= (band_sum != '0);
		last_s1 <= last_pixel;
	end

	// stage 2: signed offsets from the hexagon centre in Q.9, canopy compare
	logic signed [PX_W-1:0]  ox2, oy2, cx2, cy2;
	logic signed [NDV_W-1:0] lhs_ext;

	assign ox2     = PX_W'(origin_x_q) <<< 1;
	assign oy2     = PX_W'(origin_y_q) <<< 1;
	assign cx2     = PX_W'(center_x_q) <<< 1;
	assign cy2     = PX_W'(center_y_q) <<< 1;
	assign lhs_ext = NDV_W'(diff_s1) <<< THR_SHIFT;

	logic signed [PX_W-1:0] sdx_s2, sdy_s2;
	logic                   nz_s2, can_s2, last_s2;

	always_ff @(posedge clk) begin
		sdx_s2  <= ox2 + PX_W'(pm_x_s1) - cx2;
		sdy_s2  <= oy2 + PX_W'(pm_y_s1) - cy2;
		nz_s2   <= nz_s1;
		can_s2  <= (lhs_ext >= rhs_s1);
		last_s2 <= last_s1;
	end

	// stage 3: magnitudes
	logic [ABS_W-1:0] dx_s3, dy_s3;
	logic             nz_s3, can_s3, last_s3;

	always_ff @(posedge clk) begin
		dx_s3   <= sdx_s2[PX_W-1] ? ABS_W'(-sdx_s2) : ABS_W'(sdx_s2);
		dy_s3   <= sdy_s2[PX_W-1] ? ABS_W'(-sdy_s2) : ABS_W'(sdy_s2);
		nz_s3   <= nz_s2;
		can_s3  <= can_s2;
		last_s3 <= last_s2;
	end

	// stage 4: range checks and the slant-side margin
	logic [EDGE2_W-1:0] edge2;

	assign edge2 = {edge_q, 1'b0};

	logic [EDGE2_W-1:0] dx_s4, r_s4;
	logic [SQ_IN_W-1:0] dy_s4;
	logic               okx_s4, oky_s4, nz_s4, can_s4, last_s4;

	always_ff @(posedge clk) begin
		dx_s4   <= dx_s3[EDGE2_W-1:0];
		dy_s4   <= dy_s3[SQ_IN_W-1:0];
		r_s4    <= edge2 - dx_s3[EDGE2_W-1:0];
		okx_s4  <= (dx_s3 <= ABS_W'(edge2));
		oky_s4  <= (dy_s3[ABS_W-1:SQ_IN_W] == '0);
		nz_s4   <= nz_s3;
		can_s4  <= can_s3;
		last_s4 <= last_s3;
	end

	// stage 5: partial products of the four squares
	logic [SQ_IN_W-1:0]   lane_in [SQ_LANES];
	logic [HH_W-1:0]      hh_s5   [SQ_LANES];
	logic [SQ_IN_W-1:0]   hl_s5   [SQ_LANES];
	logic [LL_W-1:0]      ll_s5   [SQ_LANES];
	logic                 ok_s5, nz_s5, can_s5, last_s5;

	assign lane_in[LANE_DX] = SQ_IN_W'(dx_s4);
	assign lane_in[LANE_E]  = SQ_IN_W'(edge2);
	assign lane_in[LANE_DY] = dy_s4;
	assign lane_in[LANE_R]  = SQ_IN_W'(r_s4);

	always_ff @(posedge clk) begin
		for (int i = 0; i < SQ_LANES; i++) begin
			hh_s5[i] <= HH_W'(lane_in[i][SQ_IN_W-1:SQ_LO_W])
				* HH_W'(lane_in[i][SQ_IN_W-1:SQ_LO_W]);
			hl_s5[i] <= SQ_IN_W'(lane_in[i][SQ_IN_W-1:SQ_LO_W])
				* SQ_IN_W'(lane_in[i][SQ_LO_W-1:0]);
			ll_s5[i] <= LL_W'(lane_in[i][SQ_LO_W-1:0])
				* LL_W'(lane_in[i][SQ_LO_W-1:0]);
		end
		ok_s5   <= okx_s4 && oky_s4;
		nz_s5   <= nz_s4;
		can_s5  <= can_s4;
		last_s5 <= last_s4;
	end

	// stage 6: assemble the squares
	logic [SQ_W-1:0] sq_s6 [SQ_LANES];
	logic            ok_s6, nz_s6, can_s6, last_s6;

	always_ff @(posedge clk) begin
		for (int i = 0; i < SQ_LANES; i++) begin
			sq_s6[i] <= (SQ_W'(hh_s5[i]) << (2 * SQ_LO_W))
				+ (SQ_W'(hl_s5[i]) << (SQ_LO_W + 1))
				+ SQ_W'(ll_s5[i]);
		end
		ok_s6   <= ok_s5;
		nz_s6   <= nz_s5;
		can_s6  <= can_s5;
		last_s6 <= last_s5;
	end

	// stage 7: 4*dx^2 <= 3*e^2 and dy^2 <= 3*r^2
	logic [CMP_W-1:0] dx_quad, e_tri, dy_sq, r_tri;
	logic             in_hex;
	class_t           cls_s7;

	assign dx_quad = CMP_W'(sq_s6[LANE_DX]) << 2;
	assign e_tri   = (CMP_W'(sq_s6[LANE_E]) << 1) + CMP_W'(sq_s6[LANE_E]);
	assign dy_sq   = CMP_W'(sq_s6[LANE_DY]);
	assign r_tri   = (CMP_W'(sq_s6[LANE_R]) << 1) + CMP_W'(sq_s6[LANE_R]);
	assign in_hex  = ok_s6 && (dx_quad <= e_tri) && (dy_sq <= r_tri);

	always_ff @(posedge clk) begin
		cls_s7.sampled    <= nz_s6 && in_hex;
		cls_s7.canopy     <= nz_s6 && in_hex && can_s6;
		cls_s7.last_pixel <= last_s6;
	end

	assign cls_valid = vld_q[PIPE_STAGES-1];
	assign cls       = cls_s7;

endmodule
`default_nettype wire

[hdl/hzc_queue.sv]
// Short queue of classified pixels between front and back.
`timescale 1ns / 1ps
`default_nettype none
module hzc_queue import hzc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_valid,
	input  wire class_t wr_item,
	output logic        rd_valid,
	output class_t      rd_item,
	input  wire logic   rd_pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(DEPTH + 1);

	class_t             slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;
	logic               do_pop;

	assign rd_valid = (count_q != '0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign do_pop   = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (wr_valid) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/hzc_back.sv]
// Back end: saturating counters, serial fraction divider and result register.
`timescale 1ns / 1ps
`default_nettype none
module hzc_back import hzc_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	input  wire class_t       q_item,
	output logic              q_pop,
	output logic              empty,
	input  wire logic         pop,
	output logic [CNT_W-1:0]  sampled_count,
	output logic [CNT_W-1:0]  canopy_count,
	output logic [FRAC_W-1:0] canopy_share
);

	localparam int REM_W = CNT_W + 1;
	localparam int NUM_W = CNT_W + FRAC_W + 1;
	localparam int BIT_W = $clog2(FRAC_W);
	localparam logic [BIT_W-1:0] DIV_LAST = BIT_W'(FRAC_W - 1);

	back_state_t       state_q, state_d;
	logic [CNT_W-1:0]  sampled_q, canopy_q, s_next, c_next;
	logic [CNT_W-1:0]  hold_s_q, hold_c_q;
	logic [REM_W-1:0]  rem_q;
	logic [FRAC_W-1:0] quo_q;
	logic [BIT_W-1:0]  bit_cnt_q;
	logic              res_valid_q, res_load;
	logic [CNT_W-1:0]  res_s_q, res_c_q;
	logic [FRAC_W-1:0] res_f_q;

	logic [NUM_W-1:0] numer;
	logic [REM_W:0]   trial, denom;
	logic             ge;

	assign s_next = sampled_q + CNT_W'(q_item.sampled && (sampled_q != '1));
	assign c_next = canopy_q + CNT_W'(q_item.canopy && (canopy_q != '1));
	assign numer  = {1'b0, hold_c_q, {FRAC_W{1'b0}}} + NUM_W'(hold_s_q);
	assign trial  = {rem_q, quo_q[FRAC_W-1]};
	assign denom  = {1'b0, hold_s_q, 1'b0};
	assign ge     = (trial >= denom);

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			ST_COUNT: begin
				q_pop = q_valid;
				if (q_valid && q_item.last_pixel) begin
					state_d = (s_next == '0) ? ST_SEND : ST_LOAD;
				end
			end
			ST_LOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (bit_cnt_q == DIV_LAST) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				res_load = !res_valid_q || pop;
				if (res_load) begin
					state_d = ST_COUNT;
				end
			end
			default: state_d = ST_COUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COUNT;
			sampled_q   <= '0;
			canopy_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				if (q_item.last_pixel) begin
					sampled_q <= '0;
					canopy_q  <= '0;
				end else begin
					sampled_q <= s_next;
					canopy_q  <= c_next;
				end
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_COUNT: begin
				if (q_pop && q_item.last_pixel) begin
					hold_s_q <= s_next;
					hold_c_q <= c_next;
					quo_q    <= '0;
				end
			end
			ST_LOAD: begin
				rem_q     <= numer[NUM_W-1:FRAC_W];
				quo_q     <= numer[FRAC_W-1:0];
				bit_cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q     <= ge ? REM_W'(trial - denom) : REM_W'(trial);
				quo_q     <= {quo_q[FRAC_W-2:0], ge};
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			ST_SEND: begin
				if (res_load) begin
					res_s_q <= hold_s_q;
					res_c_q <= hold_c_q;
					res_f_q <= quo_q;
				end
			end
			default: ;
		endcase
	end

	assign empty         = !res_valid_q;
	assign sampled_count = res_s_q;
	assign canopy_count  = res_c_q;
	assign canopy_share  = res_f_q;

endmodule
`default_nettype wire

[hdl/hex_zone_ndvi_canopy_cover_unit.sv]
// Top level of the hexagon NDVI canopy cover unit.
`timescale 1ns / 1ps
`default_nettype none
// Counts raster pixels with a nonzero red plus NIR sum whose centres fall in
// one hexagon and, of those, the ones whose NDVI reaches the threshold; on
// the pixel marked last it queues one result with both counts and the canopy
// fraction in Q1.16, then clears its counters. Pixels are taken one per
// cycle while the QUEUE_DEPTH-entry classification queue has room; the
// hexagon and NDVI tests are pipelined from push to queue. On the pixel
// marked last the back end counts, loads, runs 17 shift-subtract divider
// steps and hands over the result once the one-entry result register is free
// (no load or divide when none sampled) while the queue fills and full rises.
module hex_zone_ndvi_canopy_cover_unit import hzc_pkg::*; #(
	parameter int INDEX_BITS  = INDEX_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [FIELD_W-1:0]    column,
	input  wire logic [FIELD_W-1:0]    row,
	input  wire logic [FIELD_W-1:0]    red_value,
	input  wire logic [FIELD_W-1:0]    nir_value,
	input  wire logic                  last_pixel,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [CNT_W-1:0]           sampled_count,
	output logic [CNT_W-1:0]           canopy_count,
	output logic [FRAC_W-1:0]          canopy_share
);

	logic   cls_valid, q_valid, q_pop;
	class_t cls, q_item;

	assign cfg_ready = 1'b1;

	hzc_front #(
		.INDEX_BITS  (INDEX_BITS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.column      (column),
		.row         (row),
		.red_value   (red_value),
		.nir_value   (nir_value),
		.last_pixel  (last_pixel),
		.cls_valid   (cls_valid),
		.cls         (cls),
		.cls_release (q_pop)
	);

	hzc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cls_valid),
		.wr_item  (cls),
		.rd_valid (q_valid),
		.rd_item  (q_item),
		.rd_pop   (q_pop)
	);

	hzc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.sampled_count (sampled_count),
		.canopy_count  (canopy_count),
		.canopy_share  (canopy_share)
	);

	a_canopy_is_sampled: assert property (@(posedge clk) disable iff (!arst_n)
		(cls_valid && cls.canopy) |-> cls.sampled)
		else $error("canopy pixel not counted as sampled");

	a_canopy_le_sampled: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (canopy_count <= sampled_count))
		else $error("canopy count exceeds sampled count");

	a_empty_fraction: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (sampled_count == '0)) |-> (canopy_share == '0))
		else $error("nonzero fraction with nothing sampled");

	a_full_fraction: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && canopy_share[FRAC_W-1]) |-> (canopy_share[FRAC_W-2:0] == '0))
		else $error("fraction above one");

endmodule
`default_nettype wire
